// ----- rtl/rit_pkg.sv -----
// ----------------------------------------------------------------------------
// rit_pkg
// Types and codes shared by the reference-counted inode table.
// ----------------------------------------------------------------------------
`default_nettype none

package rit_pkg;

    localparam int DEV_W   = 16;
    localparam int INO_W   = 32;
    localparam int CNT_W   = 16;
    localparam int SLOT_W  = 5;
    localparam int STAT_W  = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // request codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_HIT        = 3'd0,
        ST_CLAIMED    = 3'd1,
        ST_FULL       = 3'd2,
        ST_STILL_USED = 3'd3,
        ST_NOW_FREE   = 3'd4,
        ST_PUT_FREE   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_PUT,
        S_OUT
    } state_t;

    // one table entry as stored in the slot memory
    typedef struct packed {
        logic [DEV_W-1:0] device;
        logic [INO_W-1:0] inode;
        logic [CNT_W-1:0] count;
    } entry_t;

    // one result word
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
        logic              fetch;
        logic              write_back;
        logic [CNT_W-1:0]  use_count;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/rit_if.sv -----
// ----------------------------------------------------------------------------
// rit_if
// Channel interfaces of the inode table: request, response, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface rit_req_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [rit_pkg::DEV_W-1:0]       device;
    logic [rit_pkg::INO_W-1:0]       inode_number;
    logic [rit_pkg::SLOT_W-1:0]      slot_in;

    modport source (output valid, command, device, inode_number, slot_in,
                    input ready);
    modport sink   (input valid, command, device, inode_number, slot_in,
                    output ready);
endinterface

interface rit_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rit_pkg::SLOT_W-1:0]      slot;
    logic [rit_pkg::STAT_W-1:0]      status;
    logic                            fetch;
    logic                            write_back;
    logic [rit_pkg::CNT_W-1:0]       use_count;

    modport source (output valid, slot, status, fetch, write_back, use_count,
                    input ready);
    modport sink   (input valid, slot, status, fetch, write_back, use_count,
                    output ready);
endinterface

interface rit_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rit_pkg::DEV_W-1:0]       data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/refcounted_inode_table.sv -----
// ----------------------------------------------------------------------------
// refcounted_inode_table
// Reference-counted inode cache: get (lookup or claim) and put (release).
// ----------------------------------------------------------------------------
// After reset the block clears every slot of the slot memory and
// accepts no request until that pass is done (config writes are taken at
// any time). Slot state lives in one memory with one write and one
// registered read per cycle, scanned one slot per cycle. A get scans
// the table until it hits or has read every slot, then claims a free
// slot or reports the table full; a put reads the selected slot and
// releases one reference if the slot is live. The next request can be
// taken in the cycle after the result is loaded. One request is in
// flight at a time; the result sits in an output register so the next
// request is taken while it waits to be read. A result that cannot be
// loaded because the register is still full holds the block until the
// register drains.
`default_nettype none

module refcounted_inode_table #(
    parameter int SLOTS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    rit_cfg_if.sink     cfg,
    rit_req_if.sink     req,
    rit_rsp_if.source   rsp
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNTW = IDXW + 1;
    localparam int WIDEW = ((IDXW > rit_pkg::SLOT_W) ? IDXW : rit_pkg::SLOT_W) + 1;

    rit_pkg::state_t  state_reg, state_next;

    logic [CNTW-1:0]  scan_cnt_reg, scan_cnt_next;
    logic             eval_vld_reg, eval_vld_next;
    logic [IDXW-1:0]  eval_idx_reg;
    logic             have_free_reg, have_free_next;
    logic [IDXW-1:0]  free_idx_reg, free_idx_next;

    logic [rit_pkg::DEV_W-1:0]  dev_reg;
    logic [rit_pkg::INO_W-1:0]  ino_reg;
    logic [rit_pkg::SLOT_W-1:0] sel_reg;
    logic                       sel_ok_reg;
    logic [IDXW-1:0]            sel_idx_reg;
    logic [rit_pkg::DEV_W-1:0]  no_device_reg;

    rit_pkg::result_t res_reg, res_next;
    rit_pkg::result_t out_reg;
    logic             out_valid_reg, out_valid_next;

    // slot memory
    rit_pkg::entry_t  mem [SLOTS];
    rit_pkg::entry_t  rd_data_reg;
    logic [IDXW-1:0]  rd_addr;
    logic             mem_we;
    logic [IDXW-1:0]  mem_waddr;
    rit_pkg::entry_t  mem_wdata;

    logic [WIDEW-1:0] sel_wide, eval_wide, free_wide;
    logic             sel_ok;
    logic             req_fire, out_load;
    logic             key_match, eval_hit, scan_done, issue;
    logic [rit_pkg::CNT_W-1:0] cnt_inc, cnt_dec;

    // ---------------------------------------------------------------- decode
    assign sel_wide  = WIDEW'(req.slot_in);
    assign sel_ok    = sel_wide < WIDEW'(SLOTS);
    assign eval_wide = WIDEW'(eval_idx_reg);
    assign free_wide = WIDEW'(free_idx_reg);

    assign req.ready = (state_reg == rit_pkg::S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign key_match = (rd_data_reg.device == dev_reg) && (rd_data_reg.inode == ino_reg);
    assign eval_hit  = eval_vld_reg && (rd_data_reg.count != '0) && key_match;
    assign scan_done = !eval_vld_reg && (scan_cnt_reg == CNTW'(SLOTS));
    assign issue     = (state_reg == rit_pkg::S_SCAN) && (scan_cnt_reg < CNTW'(SLOTS));
    assign out_load  = (state_reg == rit_pkg::S_OUT) && (!out_valid_reg || rsp.ready);

    assign cnt_inc = (rd_data_reg.count == rit_pkg::COUNT_MAX) ? rd_data_reg.count
                                                               : rd_data_reg.count + 1'b1;
    assign cnt_dec = rd_data_reg.count - 1'b1;

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rit_pkg::S_CLEAR:
            begin
                if (scan_cnt_reg == CNTW'(SLOTS - 1))
                    state_next = rit_pkg::S_IDLE;
            end
            rit_pkg::S_IDLE:
            begin
                if (req_fire)
                    state_next = (req.command == rit_pkg::CMD_PUT) ? rit_pkg::S_PUT
                                                                   : rit_pkg::S_SCAN;
            end
            rit_pkg::S_SCAN:
            begin
                if (eval_hit || scan_done)
                    state_next = rit_pkg::S_OUT;
            end
            rit_pkg::S_PUT:
                state_next = rit_pkg::S_OUT;
            rit_pkg::S_OUT:
            begin
                if (out_load)
                    state_next = rit_pkg::S_IDLE;
            end
            default:
                state_next = rit_pkg::S_IDLE;
        endcase
    end

    // -------------------------------------------------------------- datapath
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = eval_idx_reg;
        mem_wdata      = '0;
        rd_addr        = scan_cnt_reg[IDXW-1:0];
        res_next       = res_reg;
        scan_cnt_next  = scan_cnt_reg;
        eval_vld_next  = issue;
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;

        unique case (state_reg)
            rit_pkg::S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = scan_cnt_reg[IDXW-1:0];
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            rit_pkg::S_IDLE:
            begin
                rd_addr = sel_wide[IDXW-1:0];
                if (req_fire)
                begin
                    scan_cnt_next  = '0;
                    have_free_next = 1'b0;
                end
            end
            rit_pkg::S_SCAN:
            begin
                if (issue)
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                if (eval_vld_reg && rd_data_reg.count == '0)
                begin
                    have_free_next = 1'b1;
                    free_idx_next  = eval_idx_reg;
                end
                if (eval_hit)
                begin
                    mem_we               = 1'b1;
                    mem_waddr            = eval_idx_reg;
                    mem_wdata            = rd_data_reg;
                    mem_wdata.count      = cnt_inc;
                    res_next.slot        = eval_wide[rit_pkg::SLOT_W-1:0];
                    res_next.status      = rit_pkg::ST_HIT;
                    res_next.fetch       = 1'b0;
                    res_next.write_back  = 1'b0;
                    res_next.use_count   = cnt_inc;
                end
                else if (scan_done)
                begin
                    if (have_free_reg)
                    begin
                        mem_we               = 1'b1;
                        mem_waddr            = free_idx_reg;
                        mem_wdata.device     = dev_reg;
                        mem_wdata.inode      = ino_reg;
                        mem_wdata.count      = rit_pkg::CNT_W'(1);
                        res_next.slot        = free_wide[rit_pkg::SLOT_W-1:0];
                        res_next.status      = rit_pkg::ST_CLAIMED;
                        res_next.fetch       = (dev_reg != no_device_reg);
                        res_next.write_back  = 1'b0;
                        res_next.use_count   = rit_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        res_next = '{slot: '0, status: rit_pkg::ST_FULL, fetch: 1'b0,
                                     write_back: 1'b0, use_count: '0};
                    end
                end
            end
            rit_pkg::S_PUT:
            begin
                res_next.slot  = sel_reg;
                res_next.fetch = 1'b0;
                if (!sel_ok_reg || rd_data_reg.count == '0)
                begin
                    res_next.status     = rit_pkg::ST_PUT_FREE;
                    res_next.write_back = 1'b0;
                    res_next.use_count  = '0;
                end
                else
                begin
                    mem_we              = 1'b1;
                    mem_waddr           = sel_idx_reg;
                    mem_wdata           = rd_data_reg;
                    mem_wdata.count     = cnt_dec;
                    res_next.status     = (cnt_dec == '0) ? rit_pkg::ST_NOW_FREE
                                                          : rit_pkg::ST_STILL_USED;
                    res_next.write_back = (cnt_dec == '0);
                    res_next.use_count  = cnt_dec;
                end
            end
            rit_pkg::S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register: loads when empty or being drained
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rit_pkg::S_CLEAR;
            scan_cnt_reg  <= '0;
            eval_vld_reg  <= 1'b0;
            have_free_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            no_device_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            eval_vld_reg  <= eval_vld_next;
            have_free_reg <= have_free_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                no_device_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= scan_cnt_reg[IDXW-1:0];
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        if (req_fire)
        begin
            dev_reg     <= req.device;
            ino_reg     <= req.inode_number;
            sel_reg     <= req.slot_in;
            sel_ok_reg  <= sel_ok;
            sel_idx_reg <= sel_wide[IDXW-1:0];
        end
        if (out_load)
            out_reg <= res_reg;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.slot       = out_reg.slot;
    assign rsp.status     = out_reg.status;
    assign rsp.fetch      = out_reg.fetch;
    assign rsp.write_back = out_reg.write_back;
    assign rsp.use_count  = out_reg.use_count;

endmodule

`default_nettype wire

// ----- rtl/rit_checker.sv -----
// ----------------------------------------------------------------------------
// rit_checker
// Port-level checks on the inode table's response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rit_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          rsp_valid,
    input wire                          rsp_ready,
    input wire [rit_pkg::SLOT_W-1:0]    rsp_slot,
    input wire [rit_pkg::STAT_W-1:0]    rsp_status,
    input wire                          rsp_fetch,
    input wire                          rsp_write_back,
    input wire [rit_pkg::CNT_W-1:0]     rsp_use_count
);

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot)
            && $stable(rsp_status) && $stable(rsp_use_count))
        else $error("response word changed while stalled");

    a_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_fetch |-> rsp_status == rit_pkg::ST_CLAIMED)
        else $error("fetch outside a claim");

    a_wb: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_write_back == (rsp_status == rit_pkg::ST_NOW_FREE))
        else $error("write_back does not match a freeing release");

    // count is zero exactly for results that leave no live slot
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_use_count == '0) == (rsp_status == rit_pkg::ST_FULL
            || rsp_status == rit_pkg::ST_NOW_FREE || rsp_status == rit_pkg::ST_PUT_FREE))
        else $error("use_count inconsistent with status");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == rit_pkg::ST_FULL |-> rsp_slot == '0)
        else $error("full result with nonzero slot");

endmodule

bind refcounted_inode_table rit_checker u_rit_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_slot       (rsp.slot),
    .rsp_status     (rsp.status),
    .rsp_fetch      (rsp.fetch),
    .rsp_write_back (rsp.write_back),
    .rsp_use_count  (rsp.use_count)
);

`default_nettype wire

// ----- tb/refcounted_inode_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_inode_table_tb
// Self-checking bench for the inode table. Requests and responses run on
// valid/ready channels. A shadow copy of the slot table predicts every
// response word: first a short table of directed requests, then random
// get/put traffic under several no_device settings, ending with a table
// fill, a get on the full table, a short run of hits and a put.
// ----------------------------------------------------------------------------

module refcounted_inode_table_tb;

    import rit_pkg::*;

    localparam int SLOTS     = 32;
    localparam int KEYS      = 40;
    localparam int PHASES    = 6;
    localparam int PER_PHASE = 265;
    localparam int HOLD      = 300;
    localparam int HITS      = 4;

    typedef struct packed {
        logic              cmd;
        logic [DEV_W-1:0]  dev;
        logic [INO_W-1:0]  ino;
        logic [SLOT_W-1:0] sel;
        logic              known;
        result_t           want;
    } request_row_t;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [INO_W-1:0] ino;
    } inode_key_t;

    logic clk;
    logic rst_n;

    rit_cfg_if cfg_bus ();
    rit_req_if req_bus ();
    rit_rsp_if rsp_bus ();

    refcounted_inode_table #(
        .SLOTS (SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // shadow of the slot table
    logic [DEV_W-1:0] slot_dev [SLOTS];
    logic [INO_W-1:0] slot_ino [SLOTS];
    logic [CNT_W-1:0] slot_cnt [SLOTS];
    logic [DEV_W-1:0] cur_no_device;

    result_t      pending_results [$];
    request_row_t typed_rows [$];
    inode_key_t   key_pool [KEYS];
    int           mismatches;
    bit           calm;
    bit           hold_rsp;

    // directed requests; want is typed in only where known is set
    request_row_t directed_rows [19] = '{
        '{CMD_PUT, 16'h0000, 32'h0000_0000, 5'd0,  1'b1, '{5'd0,  ST_PUT_FREE, 1'b0, 1'b0, 16'd0}},
        '{CMD_PUT, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 1'b1, '{5'd31, ST_PUT_FREE, 1'b0, 1'b0, 16'd0}},
        '{CMD_GET, 16'h0000, 32'h0000_0000, 5'd0,  1'b1, '{5'd31, ST_CLAIMED,  1'b0, 1'b0, 16'd1}},
        '{CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 1'b1, '{5'd30, ST_CLAIMED,  1'b1, 1'b0, 16'd1}},
        '{CMD_GET, 16'h0000, 32'h0000_0000, 5'd0,  1'b1, '{5'd31, ST_HIT,      1'b0, 1'b0, 16'd2}},
        '{CMD_GET, 16'hFFFF, 32'h0000_0000, 5'd0,  1'b0, '0},
        '{CMD_GET, 16'h0000, 32'hFFFF_FFFF, 5'd0,  1'b0, '0},
        '{CMD_PUT, 16'h0000, 32'h0000_0000, 5'd31, 1'b0, '0},
        '{CMD_PUT, 16'h0000, 32'h0000_0000, 5'd31, 1'b1, '{5'd31, ST_NOW_FREE, 1'b0, 1'b1, 16'd0}},
        '{CMD_PUT, 16'h0000, 32'h0000_0000, 5'd31, 1'b1, '{5'd31, ST_PUT_FREE, 1'b0, 1'b0, 16'd0}},
        '{CMD_GET, 16'h1234, 32'h89AB_CDEF, 5'd0,  1'b0, '0},
        '{CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0,  1'b0, '0},
        '{CMD_PUT, 16'h0000, 32'h0000_0000, 5'd30, 1'b0, '0},
        '{CMD_PUT, 16'h0000, 32'h0000_0000, 5'd29, 1'b0, '0},
        '{CMD_GET, 16'hAAAA, 32'h5555_5555, 5'd0,  1'b0, '0},
        '{CMD_GET, 16'h5555, 32'hAAAA_AAAA, 5'd0,  1'b0, '0},
        '{CMD_PUT, 16'hFFFF, 32'hFFFF_FFFF, 5'd15, 1'b1, '{5'd15, ST_PUT_FREE, 1'b0, 1'b0, 16'd0}},
        '{CMD_PUT, 16'h0000, 32'h0000_0000, 5'd28, 1'b0, '0},
        '{CMD_PUT, 16'h0000, 32'h0000_0000, 5'd10, 1'b1, '{5'd10, ST_PUT_FREE, 1'b0, 1'b0, 16'd0}}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

    // apply one request to the shadow table and return the response word
    function automatic result_t inode_table_step(input logic cmd, input logic [DEV_W-1:0] dev,
                                                 input logic [INO_W-1:0] ino,
                                                 input logic [SLOT_W-1:0] sel);
        result_t r;
        int      free_idx;
        bit      found;
        r        = '0;
        free_idx = -1;
        found    = 1'b0;
        if (cmd == CMD_GET)
        begin
            for (int i = 0; i < SLOTS && !found; i++)
            begin
                if (slot_cnt[i] != 0)
                begin
                    if (slot_dev[i] == dev && slot_ino[i] == ino)
                    begin
                        if (slot_cnt[i] != COUNT_MAX)
                            slot_cnt[i] = slot_cnt[i] + 1'b1;
                        r.slot      = SLOT_W'(i);
                        r.status    = ST_HIT;
                        r.use_count = slot_cnt[i];
                        found       = 1'b1;
                    end
                end
                else
                begin
                    free_idx = i;
                end
            end
            if (!found)
            begin
                if (free_idx < 0)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    slot_dev[free_idx] = dev;
                    slot_ino[free_idx] = ino;
                    slot_cnt[free_idx] = CNT_W'(1);
                    r.slot      = SLOT_W'(free_idx);
                    r.status    = ST_CLAIMED;
                    r.fetch     = (dev != cur_no_device);
                    r.use_count = CNT_W'(1);
                end
            end
        end
        else
        begin
            r.slot = sel;
            if (int'(sel) >= SLOTS || slot_cnt[sel] == 0)
            begin
                r.status = ST_PUT_FREE;
            end
            else
            begin
                slot_cnt[sel] = slot_cnt[sel] - 1'b1;
                if (slot_cnt[sel] == 0)
                begin
                    r.status     = ST_NOW_FREE;
                    r.write_back = 1'b1;
                end
                else
                begin
                    r.status    = ST_STILL_USED;
                    r.use_count = slot_cnt[sel];
                end
            end
        end
        return r;
    endfunction

    // accepted config and request words update the shadow
    always @(posedge clk)
    begin
        result_t      r;
        request_row_t row;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                cur_no_device = cfg_bus.data;
            if (req_bus.valid && req_bus.ready)
            begin
                r = inode_table_step(req_bus.command, req_bus.device,
                                     req_bus.inode_number, req_bus.slot_in);
                if (typed_rows.size() != 0)
                begin
                    row = typed_rows.pop_front();
                    if (row.known)
                        r = row.want;
                end
                pending_results.push_back(r);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t exp;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.slot       = rsp_bus.slot;
            got.status     = status_t'(rsp_bus.status);
            got.fetch      = rsp_bus.fetch;
            got.write_back = rsp_bus.write_back;
            got.use_count  = rsp_bus.use_count;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: slot=%0d status=%0d fetch=%b wb=%b count=%0d",
                             got.slot, got.status, got.fetch, got.write_back, got.use_count);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.slot !== exp.slot || got.status !== exp.status ||
                    got.fetch !== exp.fetch || got.write_back !== exp.write_back ||
                    got.use_count !== exp.use_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp slot=%0d status=%0d fetch=%b wb=%b ",
                                  "count=%0d, got slot=%0d status=%0d fetch=%b wb=%b ",
                                  "count=%0d"},
                                 exp.slot, exp.status, exp.fetch, exp.write_back,
                                 exp.use_count, got.slot, got.status, got.fetch,
                                 got.write_back, got.use_count);
                end
            end
        end
    end

    // response side: random stalls, plus one long hold when asked
    initial
    begin
        int held;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_bus.ready <= 1'b0;
                for (held = 0; held < HOLD; held++)
                    @(negedge clk);
                hold_rsp = 1'b0;
            end
            rsp_bus.ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic cmd, input logic [DEV_W-1:0] dev,
                                input logic [INO_W-1:0] ino, input logic [SLOT_W-1:0] sel);
        int gap;
        if (!calm && $urandom_range(99) < 10)
        begin
            req_bus.valid <= 1'b0;
            gap = $urandom_range(16, 1);
            repeat (gap) @(negedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.command      <= cmd;
        req_bus.device       <= dev;
        req_bus.inode_number <= ino;
        req_bus.slot_in      <= sel;
        do
            @(posedge clk);
        while (!(req_bus.valid && req_bus.ready));
        @(negedge clk);
    endtask

    task automatic write_no_device(input logic [DEV_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // mostly pool keys (hits) and puts on live slots, some noise
    task automatic send_random_request();
        int         pick;
        int         live [$];
        inode_key_t k;
        pick = $urandom_range(99);
        k    = key_pool[$urandom_range(KEYS - 1)];
        for (int i = 0; i < SLOTS; i++)
            if (slot_cnt[i] != 0)
                live.push_back(i);
        if (pick < 45 || (pick >= 55 && pick < 95 && live.size() == 0))
            send_request(CMD_GET, k.dev, k.ino, SLOT_W'($urandom));
        else if (pick < 55)
            send_request(CMD_GET, DEV_W'($urandom), $urandom, SLOT_W'($urandom));
        else if (pick < 95)
            send_request(CMD_PUT, DEV_W'($urandom), $urandom,
                         SLOT_W'(live[$urandom_range(live.size() - 1)]));
        else
            send_request(CMD_PUT, DEV_W'($urandom), $urandom, SLOT_W'($urandom));
    endtask

    initial
    begin
        int               n;
        int               fill;
        int               free;
        int               waited;
        logic [DEV_W-1:0] nd;
        inode_key_t       k;

        rst_n                = 1'b0;
        calm                 = 1'b0;
        hold_rsp             = 1'b0;
        mismatches           = 0;
        cur_no_device        = '0;
        req_bus.valid        = 1'b0;
        req_bus.command      = CMD_GET;
        req_bus.device       = '0;
        req_bus.inode_number = '0;
        req_bus.slot_in      = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.data         = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_dev[i] = '0;
            slot_ino[i] = '0;
            slot_cnt[i] = '0;
        end
        for (int i = 0; i < KEYS; i++)
        begin
            case (i % 4)
                0: k.dev = 16'h0000;
                1: k.dev = 16'hFFFF;
                2: k.dev = 16'h8001;
                default: k.dev = DEV_W'($urandom);
            endcase
            case (i % 5)
                0: k.ino = 32'hFFFF_FFFF;
                1: k.ino = 32'h0000_0000;
                default: k.ino = $urandom;
            endcase
            key_pool[i] = k;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_no_device(16'h0000);

        foreach (directed_rows[r])
        begin
            typed_rows.push_back(directed_rows[r]);
            send_request(directed_rows[r].cmd, directed_rows[r].dev,
                         directed_rows[r].ino, directed_rows[r].sel);
        end
        req_bus.valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: nd = 16'hFFFF;
                1: nd = 16'h8001;
                2: nd = 16'h0000;
                4: nd = 16'h0001;
                default: nd = DEV_W'($urandom);
            endcase
            write_no_device(nd);
            calm = (p == 2);
            for (n = 0; n < PER_PHASE; n++)
            begin
                // long response hold while requests keep coming
                if (p == 4 && n == 40)
                    hold_rsp = 1'b1;
                send_random_request();
            end
            req_bus.valid <= 1'b0;
            wait_drained();
        end

        // fill the table, hit it full, then a few hits and a put on slot 0
        calm = 1'b1;
        fill = 0;
        do
        begin
            send_request(CMD_GET, 16'hC0DE, 32'hF111_0000 + fill, '0);
            fill++;
            free = 0;
            foreach (slot_cnt[i])
                if (slot_cnt[i] == 0)
                    free++;
        end
        while (free != 0);
        send_request(CMD_GET, 16'hC0DE, 32'hF111_0000 + fill, '0);
        k.dev = slot_dev[0];
        k.ino = slot_ino[0];
        for (n = 0; n < HITS; n++)
            send_request(CMD_GET, k.dev, k.ino, '0);
        send_request(CMD_PUT, 16'h0000, 32'h0000_0000, 5'd0);
        req_bus.valid <= 1'b0;

        for (waited = 0; pending_results.size() != 0 && waited < 20000; waited++)
            @(negedge clk);
        repeat (60) @(negedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
